FILE: hw/rtl/tmlc_pkg.sv
// ----------------------------------------------------------------------------
// tmlc_pkg
// Shared types, constants and helper functions of the texture layout calculator.
// ----------------------------------------------------------------------------
package tmlc_pkg;

  localparam int MAX_LEVELS_DEF = 16;

  localparam int LVL_W    = 4;
  localparam int FACE_W   = 3;
  localparam int SLICE_W  = 11;
  localparam int DIM_W    = 15;
  localparam int DEPTH_W  = 12;
  localparam int COUNT_W  = 5;
  localparam int CODE_W   = 3;
  localparam int BPP_W    = 5;
  localparam int BYTES_W  = 32;
  localparam int LVL_SPAN = 1 << LVL_W;
  localparam int SHIFT_W  = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CODE_W-1:0]  DATA_BLOCK = 3'd5;
  localparam logic [CODE_W-1:0]  LAYOUT_BGR = 3'd6;
  localparam logic [DEPTH_W-1:0] CUBE_FACES = 12'd6;

  localparam logic [BYTES_W-1:0] RECIP6       = 32'hAAAA_AAAB;
  localparam int                 RECIP6_SHIFT = 34;

  typedef enum logic [1:0] {
    KIND_2D      = 2'd0,
    KIND_3D      = 2'd1,
    KIND_CUBE    = 2'd2,
    KIND_INVALID = 2'd3
  } tex_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_WIDTH     = 3'd0,
    REG_BASE_HEIGHT    = 3'd1,
    REG_BASE_DEPTH     = 3'd2,
    REG_LEVEL_COUNT    = 3'd3,
    REG_DATA_KIND      = 3'd4,
    REG_CHANNEL_LAYOUT = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   base_width;
    logic [DIM_W-1:0]   base_height;
    logic [DEPTH_W-1:0] base_depth;
    logic [COUNT_W-1:0] level_count;
    logic [CODE_W-1:0]  data_kind;
    logic [CODE_W-1:0]  channel_layout;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic lvl_a;
    logic lvl_b;
    logic fin_a;
    logic fin_b;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_level;
  } dp_sts_t;

  // bytes per pixel, or per 4x4 block for compressed data
  function automatic logic [BPP_W-1:0] unit_bytes(input logic [CODE_W-1:0] kind,
                                                  input logic [CODE_W-1:0] layout);
    logic [BPP_W-1:0] chan;
    logic [BPP_W-1:0] res;
    chan = layout[2] ? (layout[0] ? 5'd4 : 5'd3) : (layout[0] ? 5'd2 : 5'd1);
    case (kind)
      3'd0: res = chan;
      3'd1: res = chan << 1;
      3'd2: res = chan << 2;
      3'd3: res = chan << 1;
      3'd4: res = chan << 2;
      3'd5: res = (layout >= LAYOUT_BGR) ? 5'd0 : (layout[0] ? 5'd16 : 5'd8);
      default: res = '0;
    endcase
    return res;
  endfunction

  // dimension at a mip level, floored at one
  function automatic logic [DIM_W-1:0] shrink(input logic [DIM_W-1:0] base,
                                              input logic [SHIFT_W-1:0] sh);
    logic [DIM_W-1:0] r;
    r = base >> sh;
    return (r == '0) ? DIM_W'(1) : r;
  endfunction

endpackage

FILE: hw/rtl/tmlc_cfg_if.sv
// ----------------------------------------------------------------------------
// tmlc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tmlc_cfg_if;
  import tmlc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/tmlc_req_if.sv
// ----------------------------------------------------------------------------
// tmlc_req_if
// Request channel: mip level, cube face and slice of one query.
// ----------------------------------------------------------------------------
interface tmlc_req_if;
  import tmlc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LVL_W-1:0]   level;
  logic [FACE_W-1:0]  cube_face;
  logic [SLICE_W-1:0] slice;

  modport source (output valid, output level, output cube_face, output slice, input ready);
  modport sink   (input valid, input level, input cube_face, input slice, output ready);
endinterface

FILE: hw/rtl/tmlc_rsp_if.sv
// ----------------------------------------------------------------------------
// tmlc_rsp_if
// Response channel: texture kind, level dimensions, sizes and offsets.
// ----------------------------------------------------------------------------
interface tmlc_rsp_if;
  import tmlc_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         texture_kind;
  logic [DIM_W-1:0]   level_width;
  logic [DIM_W-1:0]   level_height;
  logic [DEPTH_W-1:0] level_depth;
  logic [BPP_W-1:0]   pixel_bytes;
  logic [BYTES_W-1:0] level_bytes;
  logic [BYTES_W-1:0] level_offset;
  logic [BYTES_W-1:0] image_bytes;
  logic [BYTES_W-1:0] face_offset;
  logic [BYTES_W-1:0] slice_offset;

  modport source (output valid, output texture_kind, output level_width,
                  output level_height, output level_depth, output pixel_bytes,
                  output level_bytes, output level_offset, output image_bytes,
                  output face_offset, output slice_offset, input ready);
  modport sink   (input valid, input texture_kind, input level_width,
                  input level_height, input level_depth, input pixel_bytes,
                  input level_bytes, input level_offset, input image_bytes,
                  input face_offset, input slice_offset, output ready);
endinterface

FILE: hw/rtl/texture_mip_layout_calc.sv
// ----------------------------------------------------------------------------
// texture_mip_layout_calc
// Mipmapped texture layout calculator: level dimensions, sizes and byte offsets.
// ----------------------------------------------------------------------------
// One query is processed at a time. The level loop walks N levels, where N is
// the larger of the stored level count (clamped to MAX_LEVELS) and the
// requested level plus one. For each level it forms the size product in the
// LVL_A and LVL_B states (width times height beside bytes times depth, then
// their product); the slice and face offset multiplies follow the loop.
// The response sits in an output register, so a new query is taken while the
// previous response waits. Configuration writes are taken every cycle and must
// only be issued while no query is in flight.
module texture_mip_layout_calc #(
  parameter int MAX_LEVELS = tmlc_pkg::MAX_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  tmlc_cfg_if.sink   cfg,
  tmlc_req_if.sink   req,
  tmlc_rsp_if.source rsp
);
  import tmlc_pkg::*;

  cfg_t    regs;
  dp_cmd_t cmd;
  dp_sts_t sts;

  tmlc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  tmlc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tmlc_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_datapath (
    .clk          (clk),
    .cfg          (regs),
    .cmd          (cmd),
    .sts          (sts),
    .level        (req.level),
    .cube_face    (req.cube_face),
    .slice        (req.slice),
    .texture_kind (rsp.texture_kind),
    .level_width  (rsp.level_width),
    .level_height (rsp.level_height),
    .level_depth  (rsp.level_depth),
    .pixel_bytes  (rsp.pixel_bytes),
    .level_bytes  (rsp.level_bytes),
    .level_offset (rsp.level_offset),
    .image_bytes  (rsp.image_bytes),
    .face_offset  (rsp.face_offset),
    .slice_offset (rsp.slice_offset)
  );
endmodule

FILE: hw/rtl/tmlc_cfg_regs.sv
// ----------------------------------------------------------------------------
// tmlc_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module tmlc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  tmlc_cfg_if.sink      cfg,
  output tmlc_pkg::cfg_t regs
);
  import tmlc_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.base_width     <= DIM_W'(1);
      regs.base_height    <= DIM_W'(1);
      regs.base_depth     <= DEPTH_W'(1);
      regs.level_count    <= COUNT_W'(1);
      regs.data_kind      <= '0;
      regs.channel_layout <= '0;
    end else if (cfg.valid) begin
      case (reg_idx_t'(cfg.index))
        REG_BASE_WIDTH:     regs.base_width     <= cfg.data[DIM_W-1:0];
        REG_BASE_HEIGHT:    regs.base_height    <= cfg.data[DIM_W-1:0];
        REG_BASE_DEPTH:     regs.base_depth     <= cfg.data[DEPTH_W-1:0];
        REG_LEVEL_COUNT:    regs.level_count    <= cfg.data[COUNT_W-1:0];
        REG_DATA_KIND:      regs.data_kind      <= cfg.data[CODE_W-1:0];
        REG_CHANNEL_LAYOUT: regs.channel_layout <= cfg.data[CODE_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tmlc_ctrl.sv
// ----------------------------------------------------------------------------
// tmlc_ctrl
// Sequencer: walks the mip levels, runs the final products, hands off the result.
// ----------------------------------------------------------------------------
module tmlc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tmlc_pkg::dp_cmd_t cmd,
  input  tmlc_pkg::dp_sts_t sts
);
  import tmlc_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    LVL_A,
    LVL_B,
    FIN_A,
    FIN_B,
    EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd       = '0;
    cmd.start = in_valid && (state == IDLE);
    cmd.lvl_a = (state == LVL_A);
    cmd.lvl_b = (state == LVL_B);
    cmd.fin_a = (state == FIN_A);
    cmd.fin_b = (state == FIN_B);
    cmd.emit  = (state == EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= LVL_A;
          end
        end
        LVL_A: state <= LVL_B;
        LVL_B: state <= sts.last_level ? FIN_A : LVL_A;
        FIN_A: state <= FIN_B;
        FIN_B: state <= EMIT;
        EMIT: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/tmlc_datapath.sv
// ----------------------------------------------------------------------------
// tmlc_datapath
// Level size products, offset accumulators, slice and face offsets, result register.
// ----------------------------------------------------------------------------
module tmlc_datapath #(
  parameter int MAX_LEVELS = tmlc_pkg::MAX_LEVELS_DEF
) (
  input  logic                          clk,
  input  tmlc_pkg::cfg_t                cfg,
  input  tmlc_pkg::dp_cmd_t             cmd,
  output tmlc_pkg::dp_sts_t             sts,
  input  logic [tmlc_pkg::LVL_W-1:0]    level,
  input  logic [tmlc_pkg::FACE_W-1:0]   cube_face,
  input  logic [tmlc_pkg::SLICE_W-1:0]  slice,
  output logic [1:0]                    texture_kind,
  output logic [tmlc_pkg::DIM_W-1:0]    level_width,
  output logic [tmlc_pkg::DIM_W-1:0]    level_height,
  output logic [tmlc_pkg::DEPTH_W-1:0]  level_depth,
  output logic [tmlc_pkg::BPP_W-1:0]    pixel_bytes,
  output logic [tmlc_pkg::BYTES_W-1:0]  level_bytes,
  output logic [tmlc_pkg::BYTES_W-1:0]  level_offset,
  output logic [tmlc_pkg::BYTES_W-1:0]  image_bytes,
  output logic [tmlc_pkg::BYTES_W-1:0]  face_offset,
  output logic [tmlc_pkg::BYTES_W-1:0]  slice_offset
);
  import tmlc_pkg::*;

  localparam int LOOP_MAX = (MAX_LEVELS > LVL_SPAN) ? MAX_LEVELS : LVL_SPAN;
  localparam int CNT_W    = $clog2(LOOP_MAX + 1);
  localparam int WH_W     = 2 * DIM_W;
  localparam int FD_W     = BPP_W + DEPTH_W;

  tex_kind_t          kind;
  logic [BPP_W-1:0]   ub;
  logic [BPP_W-1:0]   pix;
  logic               blk;
  logic [DIM_W-1:0]   w_i;
  logic [DIM_W-1:0]   h_i;
  logic [DEPTH_W-1:0] d_i;
  logic [DIM_W:0]     w_pad;
  logic [DIM_W:0]     h_pad;
  logic [DIM_W-1:0]   wx;
  logic [DIM_W-1:0]   hx;
  logic [DEPTH_W-1:0] d_eff;
  logic [CNT_W-1:0]   lim_next;
  logic [CNT_W-1:0]   lv_ext;
  logic [WH_W+FD_W-1:0]        size_full;
  logic [BYTES_W-1:0]          size;
  logic [WH_W+BPP_W-1:0]       sp1_full;
  logic [BYTES_W+SLICE_W-1:0]  sprod_full;
  logic [BYTES_W+FACE_W-1:0]   fmul_full;
  logic [2*BYTES_W-1:0]        fq_full;

  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   lim;
  logic [CNT_W-1:0]   n_last;
  logic [LVL_W-1:0]   lv;
  logic [FACE_W-1:0]  face;
  logic [SLICE_W-1:0] slc;
  logic [WH_W-1:0]    wh;
  logic [FD_W-1:0]    fd;
  logic [WH_W-1:0]    whcap;
  logic [BYTES_W-1:0] loff;
  logic [BYTES_W-1:0] img;
  logic [BYTES_W-1:0] lbytes;
  logic [BYTES_W-1:0] sp1;
  logic [BYTES_W-1:0] fsum;
  logic [BYTES_W-1:0] sprod;
  logic [BYTES_W-1:0] fq;

  always_comb begin
    if (cfg.data_kind > DATA_BLOCK) begin
      kind = KIND_INVALID;
    end else if (cfg.data_kind == DATA_BLOCK && cfg.channel_layout >= LAYOUT_BGR) begin
      kind = KIND_INVALID;
    end else if (cfg.base_depth == '0 && cfg.base_width == cfg.base_height) begin
      kind = KIND_CUBE;
    end else if (cfg.base_depth > DEPTH_W'(1)) begin
      kind = KIND_3D;
    end else if (cfg.base_depth == DEPTH_W'(1)) begin
      kind = KIND_2D;
    end else begin
      kind = KIND_INVALID;
    end
  end

  assign ub  = unit_bytes(cfg.data_kind, cfg.channel_layout);
  assign blk = (cfg.data_kind == DATA_BLOCK);
  assign pix = (cfg.data_kind < DATA_BLOCK) ? ub : '0;

  // dimensions of the level under the loop index
  assign w_i   = shrink(cfg.base_width, SHIFT_W'(idx));
  assign h_i   = shrink(cfg.base_height, SHIFT_W'(idx));
  assign d_i   = DEPTH_W'(shrink(DIM_W'(cfg.base_depth), SHIFT_W'(idx)));
  assign w_pad = {1'b0, w_i} + (DIM_W+1)'(3);
  assign h_pad = {1'b0, h_i} + (DIM_W+1)'(3);
  assign wx    = blk ? w_pad[DIM_W:2] : w_i;
  assign hx    = blk ? h_pad[DIM_W:2] : h_i;
  assign d_eff = (kind == KIND_CUBE) ? CUBE_FACES : d_i;

  assign size_full = {{FD_W{1'b0}}, wh} * {{WH_W{1'b0}}, fd};
  assign size      = size_full[BYTES_W-1:0];

  // stored level count clamped to the supported maximum
  always_comb begin
    if (32'(cfg.level_count) > 32'(MAX_LEVELS)) begin
      lim_next = CNT_W'(MAX_LEVELS);
    end else begin
      lim_next = CNT_W'(cfg.level_count);
    end
  end

  assign lv_ext          = CNT_W'(lv);
  assign sts.last_level  = (idx == n_last);

  assign sp1_full   = {{BPP_W{1'b0}}, whcap} * {{WH_W{1'b0}}, pix};
  assign fmul_full  = {{FACE_W{1'b0}}, img} * {{BYTES_W{1'b0}}, face};
  assign sprod_full = {{SLICE_W{1'b0}}, sp1} * {{BYTES_W{1'b0}}, slc};
  assign fq_full    = {{BYTES_W{1'b0}}, fsum} * {{BYTES_W{1'b0}}, RECIP6};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lv     <= level;
      face   <= cube_face;
      slc    <= slice;
      lim    <= lim_next;
      n_last <= (lim_next > CNT_W'(level)) ? (lim_next - CNT_W'(1)) : CNT_W'(level);
      idx    <= '0;
      loff   <= '0;
      img    <= '0;
      lbytes <= '0;
      whcap  <= '0;
    end
    if (cmd.lvl_a) begin
      wh <= {{DIM_W{1'b0}}, wx} * {{DIM_W{1'b0}}, hx};
      fd <= {{DEPTH_W{1'b0}}, ub} * {{BPP_W{1'b0}}, d_eff};
    end
    if (cmd.lvl_b) begin
      if (idx < lim) begin
        img <= img + size;
        if (idx < lv_ext) begin
          loff <= loff + size;
        end
      end
      if (idx == lv_ext) begin
        lbytes <= size;
        whcap  <= wh;
      end
      idx <= idx + CNT_W'(1);
    end
    if (cmd.fin_a) begin
      sp1  <= sp1_full[BYTES_W-1:0];
      fsum <= fmul_full[BYTES_W-1:0] + loff;
    end
    if (cmd.fin_b) begin
      sprod <= sprod_full[BYTES_W-1:0];
      fq    <= BYTES_W'(fq_full[2*BYTES_W-1:RECIP6_SHIFT]);
    end
    if (cmd.emit) begin
      texture_kind <= kind;
      level_width  <= shrink(cfg.base_width, SHIFT_W'(lv));
      level_height <= shrink(cfg.base_height, SHIFT_W'(lv));
      level_depth  <= DEPTH_W'(shrink(DIM_W'(cfg.base_depth), SHIFT_W'(lv)));
      pixel_bytes  <= pix;
      level_bytes  <= lbytes;
      level_offset <= loff;
      image_bytes  <= img;
      face_offset  <= (kind == KIND_CUBE) ? fq : '0;
      slice_offset <= (kind == KIND_3D) ? (loff + sprod) : '0;
    end
  end
endmodule

FILE: sim/tmlc_layout_checker.sv
// ----------------------------------------------------------------------------
// tmlc_layout_checker
// Watches the configuration, request and response channels of the texture
// layout calculator. It keeps its own copy of the layout registers, works out
// the expected response of every accepted request and compares each accepted
// response field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module tmlc_layout_checker (
  input  logic clk,
  input  logic rst,
  tmlc_cfg_if  cfg_mon,
  tmlc_req_if  req_mon,
  tmlc_rsp_if  rsp_mon,
  output int   errors,
  output int   pending,
  output int   checked
);
  import tmlc_pkg::*;

  localparam int REPORT_MAX = 10;

  // bytes per pixel by data kind and channel layout, last row per 4x4 block
  localparam logic [BPP_W-1:0] UNIT_TAB [0:5][0:7] = '{
    '{5'd1, 5'd2,  5'd1, 5'd2,  5'd3,  5'd4,  5'd3,  5'd4},
    '{5'd2, 5'd4,  5'd2, 5'd4,  5'd6,  5'd8,  5'd6,  5'd8},
    '{5'd4, 5'd8,  5'd4, 5'd8,  5'd12, 5'd16, 5'd12, 5'd16},
    '{5'd2, 5'd4,  5'd2, 5'd4,  5'd6,  5'd8,  5'd6,  5'd8},
    '{5'd4, 5'd8,  5'd4, 5'd8,  5'd12, 5'd16, 5'd12, 5'd16},
    '{5'd8, 5'd16, 5'd8, 5'd16, 5'd8,  5'd16, 5'd0,  5'd0}
  };

  typedef struct packed {
    tex_kind_t          kind;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [DEPTH_W-1:0] depth;
    logic [BPP_W-1:0]   bpp;
    logic [BYTES_W-1:0] level_bytes;
    logic [BYTES_W-1:0] level_offset;
    logic [BYTES_W-1:0] image_bytes;
    logic [BYTES_W-1:0] face_offset;
    logic [BYTES_W-1:0] slice_offset;
  } layout_t;

  logic [DIM_W-1:0]   w0, h0;
  logic [DEPTH_W-1:0] d0;
  logic [COUNT_W-1:0] n0;
  logic [CODE_W-1:0]  fmt, lay;

  layout_t layout_q [$];

  function automatic tex_kind_t kind_of();
    if (fmt > DATA_BLOCK) return KIND_INVALID;
    if (fmt == DATA_BLOCK && lay >= LAYOUT_BGR) return KIND_INVALID;
    if (d0 == '0 && w0 == h0) return KIND_CUBE;
    if (d0 > 1) return KIND_3D;
    if (d0 == 1) return KIND_2D;
    return KIND_INVALID;
  endfunction

  function automatic logic [31:0] dim_at(input logic [31:0] base, input logic [31:0] lv);
    logic [31:0] r;
    r = (lv < 32) ? (base >> lv) : 32'd0;
    return (r == 32'd0) ? 32'd1 : r;
  endfunction

  function automatic logic [31:0] pixel_size();
    if (fmt >= DATA_BLOCK) return 32'd0;
    return 32'(UNIT_TAB[fmt][lay]);
  endfunction

  function automatic logic [31:0] block_size();
    if (fmt != DATA_BLOCK) return 32'd0;
    return 32'(UNIT_TAB[DATA_BLOCK][lay]);
  endfunction

  function automatic logic [31:0] level_size(input logic [31:0] lv);
    logic [31:0] w, h, d;
    w = dim_at(32'(w0), lv);
    h = dim_at(32'(h0), lv);
    d = (kind_of() == KIND_CUBE) ? 32'(CUBE_FACES) : dim_at(32'(d0), lv);
    if (fmt == DATA_BLOCK)
      return ((w + 32'd3) >> 2) * ((h + 32'd3) >> 2) * d * block_size();
    return w * h * d * pixel_size();
  endfunction

  // sum of the stored levels below count
  function automatic logic [31:0] offset_upto(input logic [31:0] count);
    logic [31:0] lim, sum;
    int i;
    lim = (32'(n0) > MAX_LEVELS_DEF) ? 32'(MAX_LEVELS_DEF) : 32'(n0);
    if (count > lim) count = lim;
    sum = 32'd0;
    for (i = 0; i < int'(count); i++)
      sum += level_size(32'(i));
    return sum;
  endfunction

  function automatic layout_t compute_layout(input logic [LVL_W-1:0] lv_in,
                                             input logic [FACE_W-1:0] face_in,
                                             input logic [SLICE_W-1:0] slice_in);
    layout_t r;
    logic [31:0] lv, w, h, bpp, loff, img;
    lv = 32'(lv_in);
    w = dim_at(32'(w0), lv);
    h = dim_at(32'(h0), lv);
    bpp = pixel_size();
    loff = offset_upto(lv);
    img = offset_upto(32'(n0));
    r.kind = kind_of();
    r.width = DIM_W'(w);
    r.height = DIM_W'(h);
    r.depth = DEPTH_W'(dim_at(32'(d0), lv));
    r.bpp = BPP_W'(bpp);
    r.level_bytes = level_size(lv);
    r.level_offset = loff;
    r.image_bytes = img;
    r.face_offset = '0;
    r.slice_offset = '0;
    if (r.kind == KIND_CUBE)
      r.face_offset = (32'(face_in) * img + loff) / 32'd6;
    if (r.kind == KIND_3D)
      r.slice_offset = loff + w * h * bpp * 32'(slice_in);
    return r;
  endfunction

  task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("mismatch in %s: expected %0d (0x%08h), got %0d (0x%08h)",
                 name, want, want, got, got);
    end
  endtask

  always @(posedge clk) begin : watch
    layout_t want;
    if (rst) begin
      w0 = DIM_W'(1);
      h0 = DIM_W'(1);
      d0 = DEPTH_W'(1);
      n0 = COUNT_W'(1);
      fmt = '0;
      lay = '0;
      errors = 0;
      checked = 0;
      layout_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_BASE_WIDTH:     w0 = cfg_mon.data[DIM_W-1:0];
          REG_BASE_HEIGHT:    h0 = cfg_mon.data[DIM_W-1:0];
          REG_BASE_DEPTH:     d0 = cfg_mon.data[DEPTH_W-1:0];
          REG_LEVEL_COUNT:    n0 = cfg_mon.data[COUNT_W-1:0];
          REG_DATA_KIND:      fmt = cfg_mon.data[CODE_W-1:0];
          REG_CHANNEL_LAYOUT: lay = cfg_mon.data[CODE_W-1:0];
          default: ;
        endcase
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (layout_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("response transaction with no request outstanding");
        end else begin
          want = layout_q.pop_front();
          checked++;
          note_field("texture_kind", 32'(want.kind), 32'(rsp_mon.texture_kind));
          note_field("level_width", 32'(want.width), 32'(rsp_mon.level_width));
          note_field("level_height", 32'(want.height), 32'(rsp_mon.level_height));
          note_field("level_depth", 32'(want.depth), 32'(rsp_mon.level_depth));
          note_field("pixel_bytes", 32'(want.bpp), 32'(rsp_mon.pixel_bytes));
          note_field("level_bytes", want.level_bytes, rsp_mon.level_bytes);
          note_field("level_offset", want.level_offset, rsp_mon.level_offset);
          note_field("image_bytes", want.image_bytes, rsp_mon.image_bytes);
          note_field("face_offset", want.face_offset, rsp_mon.face_offset);
          note_field("slice_offset", want.slice_offset, rsp_mon.slice_offset);
        end
      end
      if (req_mon.valid && req_mon.ready)
        layout_q.push_back(compute_layout(req_mon.level, req_mon.cube_face, req_mon.slice));
    end
    pending = layout_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the texture layout calculator. A directed part covers reset
// defaults, cubes, 3D textures, compressed data, invalid layouts and the field
// extremes; a random part then runs many texture layouts with queries that
// mostly stay within the stored levels. Both channels idle at random, the
// response side holds off once for a long stretch, and the checker beside
// the block decides on the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tmlc_pkg::*;

  localparam int HOLD_CYCLES  = 200;
  localparam int QUERY_TARGET = 820;
  localparam int TAIL_CYCLES  = 60;
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = 3'd6;

  logic clk;
  logic rst;
  logic hold_go;
  int   errors, pending, checked;
  int   n_queries, n_layouts;

  tmlc_cfg_if cfg_bus ();
  tmlc_req_if req_bus ();
  tmlc_rsp_if rsp_bus ();

  texture_mip_layout_calc DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  tmlc_layout_checker u_layout_chk (
    .clk     (clk),
    .rst     (rst),
    .cfg_mon (cfg_bus),
    .req_mon (req_bus),
    .rsp_mon (rsp_bus),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int r;
    logic [DIM_W-1:0] v;
    r = $urandom_range(0, 9);
    if (r < 4) v = DIM_W'(1 << $urandom_range(0, 14));
    else if (r < 8) v = DIM_W'($urandom_range(1, 300));
    else if (r < 9) begin
      case ($urandom_range(0, 2))
        0: v = '0;
        1: v = DIM_W'(16384);
        default: v = '1;
      endcase
    end else v = DIM_W'($urandom);
    return v;
  endfunction

  function automatic cfg_t mk_layout(input int w, input int h, input int d,
                                     input int n, input int k, input int l);
    cfg_t c;
    c.base_width = DIM_W'(w);
    c.base_height = DIM_W'(h);
    c.base_depth = DEPTH_W'(d);
    c.level_count = COUNT_W'(n);
    c.data_kind = CODE_W'(k);
    c.channel_layout = CODE_W'(l);
    return c;
  endfunction

  function automatic cfg_t random_layout();
    cfg_t c;
    int r;
    c.base_width = pick_dim();
    c.base_height = pick_dim();
    c.channel_layout = CODE_W'($urandom);
    c.data_kind = ($urandom_range(0, 9) == 0) ? CODE_W'($urandom) : CODE_W'($urandom_range(0, 5));
    r = $urandom_range(0, 9);
    if (r < 7) c.level_count = COUNT_W'($urandom_range(1, 16));
    else if (r < 9) c.level_count = ($urandom_range(0, 1) == 0) ? COUNT_W'(0) : COUNT_W'(16);
    else c.level_count = COUNT_W'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c.base_depth = DEPTH_W'(1);
      4, 5: begin
        if ($urandom_range(0, 1) == 0) c.base_depth = DEPTH_W'($urandom_range(2, 16));
        else c.base_depth = DEPTH_W'($urandom_range(2, 2048));
      end
      6, 7: begin
        c.base_height = c.base_width;
        c.base_depth = '0;
      end
      8: c.base_depth = '0;
      default: c.base_depth = DEPTH_W'($urandom);
    endcase
    return c;
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
                         input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = '0;
    // stray bits above the register width
    if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
      junk = CFG_DATA_W'($urandom) & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1));
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val | junk;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic load_config(input cfg_t c);
    req_bus.valid <= 1'b0;
    wait_drained();
    @(posedge clk);
    put_reg(REG_BASE_WIDTH, CFG_DATA_W'(c.base_width), DIM_W);
    put_reg(REG_BASE_HEIGHT, CFG_DATA_W'(c.base_height), DIM_W);
    put_reg(REG_BASE_DEPTH, CFG_DATA_W'(c.base_depth), DEPTH_W);
    put_reg(REG_LEVEL_COUNT, CFG_DATA_W'(c.level_count), COUNT_W);
    put_reg(REG_DATA_KIND, CFG_DATA_W'(c.data_kind), CODE_W);
    put_reg(REG_CHANNEL_LAYOUT, CFG_DATA_W'(c.channel_layout), CODE_W);
    if ($urandom_range(0, 3) == 0)
      put_reg(SPARE_REG, CFG_DATA_W'($urandom), CFG_DATA_W);
    cfg_bus.valid <= 1'b0;
    n_layouts++;
  endtask

  task automatic send_query(input logic [LVL_W-1:0] lv, input logic [FACE_W-1:0] face,
                            input logic [SLICE_W-1:0] slc, input bit gaps);
    int gap;
    req_bus.valid     <= 1'b1;
    req_bus.level     <= lv;
    req_bus.cube_face <= face;
    req_bus.slice     <= slc;
    do @(posedge clk); while (!req_bus.ready);
    n_queries++;
    gap = gaps ? idle_len() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // response side: random stalls, quiet stretches and one long hold-off
  initial begin : drain_side
    int  stall;
    int  steady;
    bit  hold_done;
    stall = 0;
    steady = 0;
    hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else if (steady > 0) begin
        rsp_bus.ready <= 1'b1;
        steady--;
      end else if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        stall--;
      end else begin
        rsp_bus.ready <= 1'b1;
        if ($urandom_range(0, 49) == 0) steady = $urandom_range(50, 300);
        else if ($urandom_range(0, 2) == 0) stall = idle_len();
      end
    end
  end

  initial begin : main
    cfg_t lay;
    int   lim, phase, burst, k;
    bit   gaps;
    logic [LVL_W-1:0]   lv;
    logic [FACE_W-1:0]  face;
    logic [SLICE_W-1:0] slc;

    n_queries = 0;
    n_layouts = 0;
    rst <= 1'b1;
    hold_go <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= '0;
    cfg_bus.data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.level <= '0;
    req_bus.cube_face <= '0;
    req_bus.slice <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset defaults
    send_query(0, 0, 0, 1'b1);
    send_query(15, 7, 2047, 1'b1);

    // cube, faces past five, level past the count
    load_config(mk_layout(16, 16, 0, 5, 4, 5));
    send_query(0, 0, 0, 1'b1);
    send_query(3, 5, 100, 1'b1);
    send_query(2, 7, 2047, 1'b1);
    send_query(15, 1, 0, 1'b1);

    // 3d texture with wrapping sizes
    load_config(mk_layout(16384, 16384, 2048, 16, 2, 7));
    send_query(0, 0, 2047, 1'b1);
    send_query(1, 3, 1, 1'b1);
    send_query(15, 0, 1024, 1'b1);

    // compressed, odd sizes, count above the maximum
    load_config(mk_layout(13, 7, 1, 31, 5, 1));
    send_query(0, 0, 5, 1'b1);
    send_query(2, 2, 0, 1'b1);
    send_query(15, 6, 9, 1'b1);

    // compressed with bgr layouts
    load_config(mk_layout(16, 16, 1, 3, 5, 6));
    send_query(1, 0, 0, 1'b1);
    load_config(mk_layout(16, 16, 1, 3, 5, 7));
    send_query(0, 0, 0, 1'b1);

    // unknown data kinds
    load_config(mk_layout(8, 8, 4, 4, 6, 0));
    send_query(1, 0, 3, 1'b1);
    load_config(mk_layout(8, 8, 4, 4, 7, 3));
    send_query(0, 0, 1, 1'b1);

    // zero depth, not square
    load_config(mk_layout(8, 4, 0, 4, 0, 5));
    send_query(2, 4, 7, 1'b1);

    // zero sizes and zero count
    load_config(mk_layout(0, 0, 0, 0, 1, 2));
    send_query(0, 3, 0, 1'b1);

    // all-ones width, height and depth
    load_config(mk_layout(32767, 32767, 4095, 16, 1, 5));
    send_query(0, 0, 2047, 1'b1);
    send_query(15, 7, 0, 1'b1);

    phase = 0;
    while (n_queries < QUERY_TARGET) begin
      lay = random_layout();
      load_config(lay);
      burst = $urandom_range(10, 50);
      gaps = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // long hold-off on the response side while requests keep coming
        hold_go <= 1'b1;
        burst = 40;
        gaps = 1'b0;
      end
      lim = (lay.level_count > 16) ? 16 : int'(lay.level_count);
      if (lim > 15) lim = 15;
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 9) < 7) lv = LVL_W'($urandom_range(0, lim));
        else lv = LVL_W'($urandom);
        if ($urandom_range(0, 4) != 0) face = FACE_W'($urandom_range(0, 5));
        else face = FACE_W'($urandom);
        case ($urandom_range(0, 9))
          0: slc = '0;
          1: slc = '1;
          default: slc = SLICE_W'($urandom);
        endcase
        send_query(lv, face, slc, gaps);
      end
      phase++;
    end

    req_bus.valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("covered %0d queries over %0d texture layouts, %0d responses compared",
             n_queries, n_layouts, checked);
    $display("%0d field mismatches, %0d responses still outstanding", errors, pending);
    if (errors == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
